// ===== design/sha3p_pkg.sv =====
// ----------------------------------------------------------------------------
// sha3p_pkg
// Types, round constants and round functions for the three-round SHA-256
// midstate precompute pipeline.
// ----------------------------------------------------------------------------
package sha3p_pkg;

  localparam int unsigned NumRounds = 3;
  localparam int unsigned RndW      = $clog2(NumRounds);

  typedef logic [31:0]     word_t;
  typedef logic [RndW-1:0] rnd_t;

  localparam rnd_t Rnd0 = rnd_t'(0);
  localparam rnd_t Rnd1 = rnd_t'(1);
  localparam rnd_t Rnd2 = rnd_t'(2);

  localparam word_t K0 = 32'h428a2f98;
  localparam word_t K1 = 32'h71374491;
  localparam word_t K2 = 32'hb5c0fbcf;

  typedef struct packed {
    word_t mid_a;
    word_t mid_b;
    word_t mid_c;
    word_t mid_d;
    word_t mid_e;
    word_t mid_f;
    word_t mid_g;
    word_t mid_h;
    word_t msg_w0;
    word_t msg_w1;
    word_t msg_w2;
  } in_item_t;

  typedef struct packed {
    word_t out_a;
    word_t out_b;
    word_t out_c;
    word_t out_d;
    word_t out_e;
    word_t out_f;
    word_t out_g;
    word_t out_h;
  } out_item_t;

  // Working variables plus the three message words that the rounds use.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
    word_t w0;
    word_t w1;
    word_t w2;
  } pipe_t;

  function automatic word_t big_sigma0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t choose(word_t x, word_t y, word_t z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic word_t majority(word_t x, word_t y, word_t z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

  function automatic word_t round_k(rnd_t rnd);
    word_t k;
    case (rnd)
      Rnd0:    k = K0;
      Rnd1:    k = K1;
      Rnd2:    k = K2;
      default: k = K0;
    endcase
    return k;
  endfunction

  function automatic word_t round_w(pipe_t p, rnd_t rnd);
    word_t w;
    case (rnd)
      Rnd0:    w = p.w0;
      Rnd1:    w = p.w1;
      Rnd2:    w = p.w2;
      default: w = p.w0;
    endcase
    return w;
  endfunction

  // One compression round; all sums wrap modulo 2^32.
  function automatic pipe_t sha_round(pipe_t p, rnd_t rnd);
    pipe_t r;
    word_t t1;
    word_t t2;
    t1 = p.h + big_sigma1(p.e) + choose(p.e, p.f, p.g) + round_k(rnd) + round_w(p, rnd);
    t2 = big_sigma0(p.a) + majority(p.a, p.b, p.c);
    r    = p;
    r.h  = p.g;
    r.g  = p.f;
    r.f  = p.e;
    r.e  = p.d + t1;
    r.d  = p.c;
    r.c  = p.b;
    r.b  = p.a;
    r.a  = t1 + t2;
    return r;
  endfunction

endpackage

// ===== design/sha3p_stage.sv =====
// ----------------------------------------------------------------------------
// sha3p_stage
// One registered SHA-256 round stage with valid/ready flow control.
// ----------------------------------------------------------------------------
module sha3p_stage
  import sha3p_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  rnd_t  rnd_i,
  input  logic  valid_i,
  input  pipe_t data_i,
  output logic  ready_o,
  output logic  valid_o,
  output pipe_t data_o,
  input  logic  ready_i
);

  logic  valid_q;
  logic  valid_d;
  pipe_t data_q;
  pipe_t data_d;

  // The stage takes a new item when it is empty or its item moves on.
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;
  assign data_d  = sha_round(data_i, rnd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/sha256_three_round_precompute_top.sv =====
// ----------------------------------------------------------------------------
// sha256_three_round_precompute_top
// Runs three SHA-256 compression rounds on a midstate and three message words.
//
//   Port group    Dir   Handshake                  Item
//   in_*          in    in_valid_i / in_stall_o    in_item_t (midstate, w0..w2)
//   out_*         out   out_valid_o / out_stall_i  out_item_t (a..h after round 2)
//
// Each round is one register stage. An accepted item passes through the stage 0,
// stage 1 and stage 2 registers in that order, and its result is presented from
// the stage 2 register. One item can be accepted every cycle while in_stall_o is low.
// Reset clears only the stage valid bits; the pipeline is empty afterward.
// A stall on the output holds the last stage; earlier stages keep filling
// empty slots, and in_stall_o rises only once every stage holds an item.
// ----------------------------------------------------------------------------
module sha256_three_round_precompute_top
  import sha3p_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  pipe_t in_pipe;
  pipe_t s0_data;
  pipe_t s1_data;
  pipe_t s2_data;
  logic  s0_ready;
  logic  s1_ready;
  logic  s2_ready;
  logic  s0_valid;
  logic  s1_valid;
  logic  s2_valid;

  assign in_pipe = '{a:  in_item_i.mid_a,  b:  in_item_i.mid_b,
                     c:  in_item_i.mid_c,  d:  in_item_i.mid_d,
                     e:  in_item_i.mid_e,  f:  in_item_i.mid_f,
                     g:  in_item_i.mid_g,  h:  in_item_i.mid_h,
                     w0: in_item_i.msg_w0, w1: in_item_i.msg_w1,
                     w2: in_item_i.msg_w2};

  sha3p_stage u_stage0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rnd_i   (Rnd0),
    .valid_i (in_valid_i),
    .data_i  (in_pipe),
    .ready_o (s0_ready),
    .valid_o (s0_valid),
    .data_o  (s0_data),
    .ready_i (s1_ready)
  );

  sha3p_stage u_stage1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rnd_i   (Rnd1),
    .valid_i (s0_valid),
    .data_i  (s0_data),
    .ready_o (s1_ready),
    .valid_o (s1_valid),
    .data_o  (s1_data),
    .ready_i (s2_ready)
  );

  sha3p_stage u_stage2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rnd_i   (Rnd2),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .ready_o (s2_ready),
    .valid_o (s2_valid),
    .data_o  (s2_data),
    .ready_i (!out_stall_i)
  );

  assign in_stall_o  = !s0_ready;
  assign out_valid_o = s2_valid;
  assign out_item_o  = '{out_a: s2_data.a, out_b: s2_data.b,
                         out_c: s2_data.c, out_d: s2_data.d,
                         out_e: s2_data.e, out_f: s2_data.f,
                         out_g: s2_data.g, out_h: s2_data.h};

endmodule
